[sv/sitc_pkg.sv]
package sitc_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int NUM_CELLS    = VALUE_BITS;
    localparam int DIGIT_BITS   = 4;
    localparam int RADIX_BITS   = 5;
    localparam int MODE_BITS    = 3;
    localparam int CHAR_BITS    = 8;
    localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);
    localparam int REMAIN_BITS  = $clog2(NUM_CELLS + 1);

    localparam logic [MODE_BITS-1:0] MODE_BINARY  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_OCTAL   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_DECIMAL = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_HEX     = 3'd3;

    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2d;

    localparam logic [CHAR_BITS-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_CONVERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [RADIX_BITS-1:0] radix;
    } cell_ctrl_t;

    typedef struct packed {
        logic                  carry;
        logic [DIGIT_BITS-1:0] digit;
    } cell_link_t;

    function automatic logic [RADIX_BITS-1:0] mode_radix(input logic [MODE_BITS-1:0] mode);
        logic [RADIX_BITS-1:0] r;
        case (mode)
            MODE_BINARY:  r = 5'd2;
            MODE_OCTAL:   r = 5'd8;
            MODE_DECIMAL: r = 5'd10;
            MODE_HEX:     r = 5'd16;
            default:      r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [DIGIT_BITS-1:0] digit);
        return DIGIT_CHARS[digit];
    endfunction

endpackage

[sv/sitc_value_if.sv]
interface sitc_value_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sitc_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[sv/sitc_char_if.sv]
interface sitc_char_if;
    logic                            valid;
    logic                            ready;
    logic [sitc_pkg::CHAR_BITS-1:0]  ascii_char;
    logic                            last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

[sv/sitc_cfg_if.sv]
interface sitc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sitc_pkg::MODE_BITS-1:0] radix_mode;

    modport source (output valid, output radix_mode, input ready);
    modport sink   (input valid, input radix_mode, output ready);
endinterface

[sv/sitc_cell.sv]
module sitc_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sitc_pkg::cell_ctrl_t ctrl,
    input  sitc_pkg::cell_link_t lin,
    output sitc_pkg::cell_link_t lout
);
    import sitc_pkg::*;

    logic [DIGIT_BITS-1:0] digit_reg;
    logic [DIGIT_BITS-1:0] digit_next;
    logic [DIGIT_BITS:0]   doubled;

    assign doubled = {digit_reg, lin.carry};

    always_comb
    begin
        case (ctrl.op)
            CELL_CLEAR:   digit_next = '0;
            CELL_CONVERT:
            begin
                if (doubled >= ctrl.radix)
                begin
                    digit_next = DIGIT_BITS'(doubled - ctrl.radix);
                end
                else
                begin
                    digit_next = doubled[DIGIT_BITS-1:0];
                end
            end
            CELL_SHIFT:   digit_next = lin.digit;
            default:      digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    // carry out depends only on the held digit and the radix, not on the carry in, so no ripple along the row
    assign lout.carry = ({digit_reg, 1'b0} >= ctrl.radix);
    assign lout.digit = digit_reg;

endmodule

[sv/sitc_chain.sv]
module sitc_chain (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sitc_pkg::cell_ctrl_t              ctrl,
    input  logic                              shift_in,
    output logic [sitc_pkg::DIGIT_BITS-1:0]   top_digit
);
    import sitc_pkg::*;

    cell_link_t links [NUM_CELLS+1];

    assign links[0].carry = shift_in;
    assign links[0].digit = '0;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        sitc_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .ctrl (ctrl),
            .lin  (links[i]),
            .lout (links[i+1])
        );
    end

    assign top_digit = links[NUM_CELLS].digit;

endmodule

[sv/signed_int_to_radix_ascii.sv]
// Converts each accepted signed 32-bit value to ASCII text in the radix held by the mode
// register (0 binary, 1 octal, 2 decimal, 3 lowercase hex; any other mode swallows the
// request and emits nothing), most significant digit first, with a leading '-' for negative
// values and last_char set on the final character. The magnitude is shifted one bit per cycle
// into a row of 32 digit cells, then the row is shifted out one cell per cycle, an emitted
// cell waiting while the output is stalled and leading zero cells being dropped without
// output. A request goes through accept, conversion, a sign step if negative, then drain.
// A request in an unsupported mode is accepted and dropped while idle. The next request is
// taken while the final character still waits in the output register. Mode writes are
// accepted at any time and the mode resets to decimal.
module signed_int_to_radix_ascii (
    input  logic         clk,
    input  logic         rst_n,
    sitc_cfg_if.sink     cfg,
    sitc_value_if.sink   value_chan,
    sitc_char_if.source  char_chan
);
    import sitc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t                  state_reg,    state_next;
    logic [MODE_BITS-1:0]    mode_reg,     mode_next;
    logic [RADIX_BITS-1:0]   radix_reg,    radix_next;
    logic [VALUE_BITS-1:0]   mag_reg,      mag_next;
    logic                    neg_reg,      neg_next;
    logic [BIT_CNT_BITS-1:0] bit_cnt_reg,  bit_cnt_next;
    logic [REMAIN_BITS-1:0]  remain_reg,   remain_next;
    logic                    lead_reg,     lead_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0]    out_char_reg, out_char_next;
    logic                    out_last_reg, out_last_next;

    logic                    in_accept;
    logic [VALUE_BITS-1:0]   in_bits;
    logic [RADIX_BITS-1:0]   in_radix;
    logic                    out_free;
    logic                    load_out;
    logic                    load_char;
    logic                    load_last;
    cell_ctrl_t              cell_ctrl;
    logic [DIGIT_BITS-1:0]   top_digit;

    assign cfg.ready  = 1'b1;
    assign mode_next  = (cfg.valid && cfg.ready) ? cfg.radix_mode : mode_reg;

    assign value_chan.ready = (state_reg == S_IDLE);
    assign in_accept        = value_chan.valid && value_chan.ready;
    assign in_bits          = value_chan.value;
    assign in_radix         = mode_radix(mode_reg);
    assign out_free         = !out_valid_reg || char_chan.ready;

    always_comb
    begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        remain_next    = remain_reg;
        lead_next      = lead_reg;
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.radix = radix_reg;
        load_out       = 1'b0;
        load_char      = 1'b0;
        load_last      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_radix != '0))
                begin
                    radix_next   = in_radix;
                    neg_next     = in_bits[VALUE_BITS-1];
                    mag_next     = in_bits[VALUE_BITS-1] ? (~in_bits + VALUE_BITS'(1)) : in_bits;
                    bit_cnt_next = '0;
                    lead_next    = 1'b1;
                    cell_ctrl.op = CELL_CLEAR;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                cell_ctrl.op = CELL_CONVERT;
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_BITS'(1);
                if (bit_cnt_reg == BIT_CNT_BITS'(VALUE_BITS - 1))
                begin
                    remain_next = REMAIN_BITS'(NUM_CELLS);
                    state_next  = neg_reg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // leading zero cells are dropped without output
                if (lead_reg && (remain_reg != REMAIN_BITS'(1)) && (top_digit == '0))
                begin
                    cell_ctrl.op = CELL_SHIFT;
                    remain_next  = remain_reg - REMAIN_BITS'(1);
                end
                else if (out_free)
                begin
                    load_out     = 1'b1;
                    load_char    = 1'b1;
                    load_last    = (remain_reg == REMAIN_BITS'(1));
                    lead_next    = 1'b0;
                    cell_ctrl.op = CELL_SHIFT;
                    remain_next  = remain_reg - REMAIN_BITS'(1);
                    if (remain_reg == REMAIN_BITS'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (char_chan.ready ? 1'b0 : out_valid_reg);
    assign out_char_next  = load_out ? (load_char ? digit_ascii(top_digit) : ASCII_MINUS)
                                     : out_char_reg;
    assign out_last_next  = load_out ? load_last : out_last_reg;

    sitc_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .shift_in (mag_reg[VALUE_BITS-1]),
        .top_digit(top_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_DECIMAL;
            bit_cnt_reg   <= '0;
            remain_reg    <= '0;
            lead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            bit_cnt_reg   <= bit_cnt_next;
            remain_reg    <= remain_next;
            lead_reg      <= lead_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg    <= radix_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign char_chan.valid      = out_valid_reg;
    assign char_chan.ascii_char = out_char_reg;
    assign char_chan.last_char  = out_last_reg;

`ifndef SYNTHESIS
    a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> remain_reg != '0)
        else $error("digit count ran out while draining");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && load_out && load_last) |=> state_reg == S_IDLE)
        else $error("final character did not end the request");

    a_conv_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV && bit_cnt_reg == BIT_CNT_BITS'(VALUE_BITS - 1))
        |=> remain_reg == REMAIN_BITS'(NUM_CELLS))
        else $error("digit count not loaded after conversion");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_chan.valid && char_chan.ascii_char == ASCII_MINUS) |-> !char_chan.last_char)
        else $error("sign flagged as final character");
`endif

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sitc_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_NO_BASE = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_7 = 3'd7;

    localparam int    SETTLE_CYCLES = 80;
    localparam string DIGIT_SET     = "0123456789abcdef";

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } text_char_t;

    typedef struct {
        logic [MODE_BITS-1:0]  mode;
        logic [VALUE_BITS-1:0] value;
        bit                    typed;
        string                 text;
    } text_case_t;

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_style_t;

    logic clk;
    logic rst_n;

    sitc_cfg_if   cfg_bus ();
    sitc_value_if value_bus ();
    sitc_char_if  char_bus ();

    signed_int_to_radix_ascii u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .value_chan (value_bus),
        .char_chan  (char_bus)
    );

    text_char_t           expected_text [$];
    logic [MODE_BITS-1:0] current_mode;
    int                   mismatch_count;
    int                   burst_left;
    bit                   sender_gaps;

    // rows with typed text are checked against that text, the rest against the predictor
    text_case_t directed_cases [24] = '{
        '{MODE_DECIMAL, 32'h0000_0000, 1'b1, "0"},
        '{MODE_DECIMAL, 32'h7fff_ffff, 1'b1, "2147483647"},
        '{MODE_DECIMAL, 32'h8000_0000, 1'b1, "-2147483648"},
        '{MODE_DECIMAL, 32'hffff_ffff, 1'b1, "-1"},
        '{MODE_DECIMAL, 32'h0000_3039, 1'b0, ""},
        '{MODE_DECIMAL, 32'hfffe_1dc0, 1'b0, ""},
        '{MODE_DECIMAL, 32'h0000_000a, 1'b0, ""},
        '{MODE_BINARY,  32'h0000_0000, 1'b1, "0"},
        '{MODE_BINARY,  32'h0000_0001, 1'b1, "1"},
        '{MODE_BINARY,  32'h8000_0000, 1'b1, "-10000000000000000000000000000000"},
        '{MODE_BINARY,  32'h7fff_ffff, 1'b1, "1111111111111111111111111111111"},
        '{MODE_BINARY,  32'h5555_5555, 1'b0, ""},
        '{MODE_OCTAL,   32'h8000_0000, 1'b1, "-20000000000"},
        '{MODE_OCTAL,   32'h7fff_ffff, 1'b1, "17777777777"},
        '{MODE_OCTAL,   32'h0000_0008, 1'b0, ""},
        '{MODE_HEX,     32'h7fff_ffff, 1'b1, "7fffffff"},
        '{MODE_HEX,     32'h8000_0000, 1'b1, "-80000000"},
        '{MODE_HEX,     32'hdead_beef, 1'b0, ""},
        '{MODE_HEX,     32'h0000_0000, 1'b1, "0"},
        '{MODE_NO_BASE, 32'h1234_5678, 1'b1, ""},
        '{MODE_NO_BASE, 32'h8000_0000, 1'b1, ""},
        '{MODE_SPARE_5, 32'hffff_ffff, 1'b1, ""},
        '{MODE_SPARE_6, 32'h0000_0000, 1'b1, ""},
        '{MODE_SPARE_7, 32'h0000_0001, 1'b1, ""}
    };

    logic [MODE_BITS-1:0] mode_plan [15] = '{
        MODE_BINARY, MODE_HEX, MODE_OCTAL, MODE_DECIMAL, MODE_NO_BASE,
        MODE_BINARY, MODE_DECIMAL, MODE_SPARE_7, MODE_HEX, MODE_OCTAL,
        MODE_DECIMAL, MODE_BINARY, MODE_HEX, MODE_OCTAL, MODE_DECIMAL
    };

    function automatic int unsigned radix_of(input logic [MODE_BITS-1:0] mode);
        int unsigned base;
        case (mode)
            MODE_BINARY:  base = 2;
            MODE_OCTAL:   base = 8;
            MODE_DECIMAL: base = 10;
            MODE_HEX:     base = 16;
            default:      base = 0;
        endcase
        return base;
    endfunction

    function automatic void predict_text(input logic [MODE_BITS-1:0] mode,
                                         input logic [VALUE_BITS-1:0] value);
        int unsigned          base;
        logic [VALUE_BITS-1:0] mag;
        logic [CHAR_BITS-1:0] digits [$];
        base = radix_of(mode);
        if (base == 0)
            return;
        mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        do begin
            digits.push_front(DIGIT_SET[mag % base]);
            mag = mag / base;
        end while (mag != 0);
        if (value[VALUE_BITS-1])
            expected_text.push_back('{ASCII_MINUS, 1'b0});
        foreach (digits[i])
            expected_text.push_back('{digits[i], i == digits.size() - 1});
    endfunction

    function automatic void load_text(input string text);
        for (int i = 0; i < text.len(); i++)
            expected_text.push_back('{text[i], i == text.len() - 1});
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value(input logic [MODE_BITS-1:0] mode);
        logic [VALUE_BITS-1:0] v;
        longint unsigned       p;
        int unsigned           base;
        base = radix_of(mode);
        case ($urandom_range(0, 9))
            4: v = $urandom_range(0, 300);
            5: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h7fff_ffff;
                    default: v = 32'h8000_0000;
                endcase
            end
            6: begin
                // near a power of the radix, so the digit count just changes
                p = 1;
                if (base != 0)
                    repeat ($urandom_range(1, 31))
                        if (p * base < 64'h8000_0000)
                            p = p * base;
                v = 32'(p) - $urandom_range(0, 1);
            end
            7: v = $urandom & ((32'h1 << $urandom_range(1, 31)) - 1);
            default: v = $urandom;
        endcase
        if (v[VALUE_BITS-1] == 1'b0 && $urandom_range(0, 3) == 0)
            v = ~v + 1'b1;
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_BITS-1:0] value, input bit typed,
                              input string text);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (sender_gaps)
                gap = $urandom_range(1, 15);
        end
        burst_left--;
        if (gap > 0)
        begin
            value_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        value_bus.valid <= 1'b1;
        value_bus.value <= value;
        do @(posedge clk); while (!value_bus.ready);
        if (typed)
            load_text(text);
        else
            predict_text(current_mode, value);
        @(negedge clk);
    endtask

    task automatic wait_results_done();
        value_bus.valid <= 1'b0;
        @(negedge clk);
        while (expected_text.size() != 0)
            @(negedge clk);
    endtask

    task automatic drain_and_settle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_radix_mode(input logic [MODE_BITS-1:0] mode);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.radix_mode <= mode;
        do @(posedge clk); while (!cfg_bus.ready);
        current_mode = mode;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver stall pattern
    initial
    begin
        ready_style_t style;
        int           span;
        char_bus.ready = 1'b0;
        style = READY_ALWAYS;
        span  = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                style = ready_style_t'($urandom_range(0, 3));
                span  = $urandom_range(20, 300);
            end
            span--;
            case (style)
                READY_ALWAYS:   char_bus.ready <= 1'b1;
                READY_COIN:     char_bus.ready <= 1'($urandom_range(0, 1));
                READY_SPARSE:   char_bus.ready <= ($urandom_range(0, 7) == 0);
                default:        char_bus.ready <= (span % 6 < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin : char_check
        text_char_t want;
        if (rst_n && char_bus.valid && char_bus.ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("ascii_char: expected none, actual %h", char_bus.ascii_char);
                mismatch_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (char_bus.ascii_char !== want.ch)
                begin
                    $error("ascii_char: expected %h, actual %h", want.ch, char_bus.ascii_char);
                    mismatch_count++;
                end
                if (char_bus.last_char !== want.last)
                begin
                    $error("last_char: expected %b, actual %b", want.last, char_bus.last_char);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int count;
        rst_n              = 1'b0;
        value_bus.valid    = 1'b0;
        value_bus.value    = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.radix_mode = MODE_DECIMAL;
        current_mode       = MODE_DECIMAL;
        mismatch_count     = 0;
        burst_left         = 0;
        sender_gaps        = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests, mode taken from reset until the first change
        foreach (directed_cases[i])
        begin
            if (directed_cases[i].mode != current_mode)
            begin
                drain_and_settle();
                write_radix_mode(directed_cases[i].mode);
            end
            send_value(directed_cases[i].value, directed_cases[i].typed,
                       directed_cases[i].text);
        end

        // random requests in phases, one mode per phase
        foreach (mode_plan[phase])
        begin
            drain_and_settle();
            write_radix_mode(mode_plan[phase]);
            sender_gaps = ($urandom_range(0, 3) != 0);
            count = (radix_of(mode_plan[phase]) != 0) ? 40 : 8;
            for (int i = 0; i < count; i++)
            begin
                if ((phase == 1 && i == count / 2) || $urandom_range(0, 39) == 0)
                    wait_results_done();
                send_value(pick_value(mode_plan[phase]), 1'b0, "");
            end
        end

        drain_and_settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
